>>> rtl/core/chrt_pkg.sv
// ----------------------------------------------------------------------------
// chrt_pkg
// Shared types and codes for the consistent-hash ring table.
// ----------------------------------------------------------------------------
package chrt_pkg;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_LOOKUP = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_EMPTY   = 2'd1,
        STAT_FULL    = 2'd2,
        STAT_NOMATCH = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_APPLY,
        S_DONE
    } ring_state_t;

    localparam int OWNER_BITS = 8;
    localparam int KEY_IN_BITS = 32;

endpackage

>>> rtl/core/consistent_hash_ring_table_top.sv
// ----------------------------------------------------------------------------
// consistent_hash_ring_table_top
// Ring of partition points with owning buckets: insert, remove, lookup, clear.
// ----------------------------------------------------------------------------
// Sequence: insert/remove/lookup sweep every slot through the registered read
//   port, let the read pipeline drain, write back in S_APPLY and register the
//   result in S_DONE; a clear zeroes every slot and then answers in S_DONE.
// Occupancy: one request at a time, set by the single read port sweeping every
//   slot per request; the next is taken once the result is in the output register.
// Reset: asynchronous, active low. After reset a clearing pass over every slot
//   zeroes the memory; no request is taken until it ends.
// ----------------------------------------------------------------------------
module consistent_hash_ring_table_top #(
    parameter int ENTRIES    = 64,
    parameter int POINT_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    // request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [31:0] key_point, [39:32] bucket_id
    input  logic [1:0]  s_tuser,   // [1:0] command
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] found_bucket
    output logic [1:0]  m_tuser    // [1:0] status
);
    import chrt_pkg::*;

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    // memory word: {valid, owner, point}
    localparam int MW = 1 + OWNER_BITS + POINT_BITS;
    localparam logic [CW-1:0] CNT_END = CW'(ENTRIES);

    ring_state_t state_reg, state_next;

    // captured request
    cmd_t                  cmd_reg;
    logic [POINT_BITS-1:0] key_reg;
    logic [OWNER_BITS-1:0] bid_reg;
    logic                  clr_rsp_reg;   // clear pass answers a request

    // sweep counter and read pipeline
    logic [CW-1:0] cnt_reg;
    logic          rd_valid_reg;

    // scan results
    logic                  match_hit_reg;
    logic [AW-1:0]         match_idx_reg;
    logic [OWNER_BITS-1:0] match_own_reg;
    logic                  free_hit_reg;
    logic [AW-1:0]         free_idx_reg;
    logic                  min_hit_reg;
    logic [POINT_BITS-1:0] min_pt_reg;
    logic [OWNER_BITS-1:0] min_own_reg;
    logic                  gt_hit_reg;
    logic [POINT_BITS-1:0] gt_pt_reg;
    logic [OWNER_BITS-1:0] gt_own_reg;

    // pending result and output register
    logic [OWNER_BITS-1:0] res_found_reg;
    status_t               res_status_reg;
    logic                  m_tvalid_reg;
    logic [OWNER_BITS-1:0] m_found_reg;
    status_t               m_status_reg;

    // memory
    logic [MW-1:0] ring_mem [ENTRIES];
    logic [MW-1:0] mem_rdata_reg;
    logic          mem_re;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [MW-1:0] mem_wdata;

    logic                  in_fire;
    logic                  out_free;
    logic                  sweep_busy;
    logic                  e_valid;
    logic [OWNER_BITS-1:0] e_own;
    logic [POINT_BITS-1:0] e_pt;

    // apply-step decisions
    logic                  apl_we;
    logic [AW-1:0]         apl_idx;
    logic [MW-1:0]         apl_data;
    logic [OWNER_BITS-1:0] apl_found;
    status_t               apl_status;

    assign in_fire    = s_tvalid && s_tready;
    assign out_free   = !m_tvalid_reg || m_tready;
    assign sweep_busy = (cnt_reg != CNT_END);

    assign e_valid = mem_rdata_reg[MW-1];
    assign e_own   = mem_rdata_reg[MW-2 -: OWNER_BITS];
    assign e_pt    = mem_rdata_reg[POINT_BITS-1:0];

    // ------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (!sweep_busy)
                    state_next = clr_rsp_reg ? S_DONE : S_IDLE;
            end
            S_IDLE:
            begin
                if (s_tvalid)
                    state_next = (cmd_t'(s_tuser) == CMD_CLEAR) ? S_CLEAR : S_SCAN;
            end
            S_SCAN:
            begin
                if (!sweep_busy && !rd_valid_reg)
                    state_next = S_APPLY;
            end
            S_APPLY:
                state_next = S_DONE;
            S_DONE:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // write-back decision, from the scan results
    // ------------------------------------------------------------------
    always_comb
    begin
        apl_we     = 1'b0;
        apl_idx    = match_idx_reg;
        apl_data   = {1'b1, bid_reg, key_reg};
        apl_found  = '0;
        apl_status = STAT_OK;
        unique case (cmd_reg)
            CMD_INSERT:
            begin
                // equal point is overwritten, else lowest free slot
                if (match_hit_reg)
                    apl_we = 1'b1;
                else if (free_hit_reg)
                begin
                    apl_we  = 1'b1;
                    apl_idx = free_idx_reg;
                end
                else
                    apl_status = STAT_FULL;
            end
            CMD_REMOVE:
            begin
                apl_data = '0;
                if (match_hit_reg && (match_own_reg == bid_reg))
                    apl_we = 1'b1;
                else
                    apl_status = STAT_NOMATCH;
            end
            CMD_LOOKUP:
            begin
                // wrap to the smallest point when none is greater
                if (!min_hit_reg)
                    apl_status = STAT_EMPTY;
                else if (gt_hit_reg)
                    apl_found = gt_own_reg;
                else
                    apl_found = min_own_reg;
            end
            CMD_CLEAR:
                apl_we = 1'b0;
            default:
                apl_we = 1'b0;
        endcase
    end

    // ------------------------------------------------------------------
    // state outputs: handshake and memory control
    // ------------------------------------------------------------------
    always_comb
    begin
        s_tready  = 1'b0;
        mem_re    = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = cnt_reg[AW-1:0];
        mem_wdata = '0;
        unique case (state_reg)
            S_CLEAR:
                mem_we = sweep_busy;
            S_IDLE:
                s_tready = 1'b1;
            S_SCAN:
                mem_re = sweep_busy;
            S_APPLY:
            begin
                mem_we    = apl_we;
                mem_waddr = apl_idx;
                mem_wdata = apl_data;
            end
            S_DONE:
                s_tready = 1'b0;
            default:
                s_tready = 1'b0;
        endcase
    end

    // ------------------------------------------------------------------
    // ring memory: one write port, one registered read port
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (mem_we)
            ring_mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            mem_rdata_reg <= ring_mem[cnt_reg[AW-1:0]];
    end

    // ------------------------------------------------------------------
    // control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            cnt_reg      <= '0;
            rd_valid_reg <= 1'b0;
            clr_rsp_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_valid_reg <= mem_re;
            if (in_fire)
            begin
                cnt_reg     <= '0;
                clr_rsp_reg <= (cmd_t'(s_tuser) == CMD_CLEAR);
            end
            else if (((state_reg == S_CLEAR) || (state_reg == S_SCAN)) && sweep_busy)
                cnt_reg <= cnt_reg + 1'b1;

            if ((state_reg == S_DONE) && out_free)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cmd_reg        <= cmd_t'(s_tuser);
            key_reg        <= POINT_BITS'(s_tdata[KEY_IN_BITS-1:0]);
            bid_reg        <= s_tdata[KEY_IN_BITS +: OWNER_BITS];
            match_hit_reg  <= 1'b0;
            free_hit_reg   <= 1'b0;
            min_hit_reg    <= 1'b0;
            gt_hit_reg     <= 1'b0;
            res_found_reg  <= '0;
            res_status_reg <= STAT_OK;
        end
        else if ((state_reg == S_SCAN) && rd_valid_reg)
        begin
            // slot index of the word now on the read port
            if (e_valid && (e_pt == key_reg) && !match_hit_reg)
            begin
                match_hit_reg <= 1'b1;
                match_idx_reg <= AW'(cnt_reg - 1'b1);
                match_own_reg <= e_own;
            end
            if (!e_valid && !free_hit_reg)
            begin
                free_hit_reg <= 1'b1;
                free_idx_reg <= AW'(cnt_reg - 1'b1);
            end
            if (e_valid && (!min_hit_reg || (e_pt < min_pt_reg)))
            begin
                min_hit_reg <= 1'b1;
                min_pt_reg  <= e_pt;
                min_own_reg <= e_own;
            end
            if (e_valid && (e_pt > key_reg) && (!gt_hit_reg || (e_pt < gt_pt_reg)))
            begin
                gt_hit_reg <= 1'b1;
                gt_pt_reg  <= e_pt;
                gt_own_reg <= e_own;
            end
        end
        else if (state_reg == S_APPLY)
        begin
            res_found_reg  <= apl_found;
            res_status_reg <= apl_status;
        end

        if ((state_reg == S_DONE) && out_free)
        begin
            m_found_reg  <= res_found_reg;
            m_status_reg <= res_status_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_found_reg;
    assign m_tuser  = m_status_reg;

endmodule

>>> dv/consistent_hash_ring_table_checker.sv
// ----------------------------------------------------------------------------
// consistent_hash_ring_table_checker
// Watches both stream channels of the ring table, keeps its own copy of the
// ring, predicts the reply to every accepted request and compares replies in
// order.
// ----------------------------------------------------------------------------
module consistent_hash_ring_table_checker #(
    parameter int ENTRIES    = 64,
    parameter int POINT_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,   // [31:0] key_point, [39:32] bucket_id
    input  logic [1:0]  s_tuser,   // [1:0] command
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,   // [7:0] found_bucket
    input  logic [1:0]  m_tuser,   // [1:0] status
    output int          fail_count,
    output int          pending,
    output int          replies_checked,
    output int          full_seen,
    output int          nomatch_seen,
    output int          empty_seen,
    output int          wrap_seen
);
    import chrt_pkg::*;

    localparam logic [31:0] KEY_MASK = (POINT_BITS >= 32) ? 32'hFFFF_FFFF
                                     : 32'((64'd1 << POINT_BITS) - 64'd1);

    typedef struct packed {
        logic [7:0] bucket;
        status_t    status;
    } ring_reply_t;

    logic [31:0] ring_point [ENTRIES];
    logic [7:0]  ring_owner [ENTRIES];
    logic        ring_used  [ENTRIES];
    ring_reply_t replies_due [$];

    function automatic int slot_of(logic [31:0] key);
        for (int i = 0; i < ENTRIES; i++)
            if (ring_used[i] && ring_point[i] == key)
                return i;
        return -1;
    endfunction

    // one ring operation: updates the shadow ring and returns the reply
    function automatic ring_reply_t ring_apply(cmd_t cmd, logic [31:0] key_in,
                                               logic [7:0] bid);
        ring_reply_t r;
        logic [31:0] key;
        int slot;
        int best_gt;
        int best_min;
        key      = key_in & KEY_MASK;
        r.bucket = '0;
        r.status = STAT_OK;
        best_gt  = -1;
        best_min = -1;
        case (cmd)
            CMD_INSERT:
            begin
                slot = slot_of(key);
                if (slot < 0)
                begin
                    for (int i = 0; i < ENTRIES; i++)
                        if (!ring_used[i])
                        begin
                            slot = i;
                            break;
                        end
                end
                if (slot < 0)
                    r.status = STAT_FULL;
                else
                begin
                    ring_point[slot] = key;
                    ring_owner[slot] = bid;
                    ring_used[slot]  = 1'b1;
                end
            end
            CMD_REMOVE:
            begin
                slot = slot_of(key);
                if (slot >= 0 && ring_owner[slot] == bid)
                    ring_used[slot] = 1'b0;
                else
                    r.status = STAT_NOMATCH;
            end
            CMD_LOOKUP:
            begin
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (!ring_used[i])
                        continue;
                    if (best_min < 0 || ring_point[i] < ring_point[best_min])
                        best_min = i;
                    if (ring_point[i] > key &&
                        (best_gt < 0 || ring_point[i] < ring_point[best_gt]))
                        best_gt = i;
                end
                if (best_min < 0)
                    r.status = STAT_EMPTY;
                else if (best_gt >= 0)
                    r.bucket = ring_owner[best_gt];
                else
                begin
                    r.bucket = ring_owner[best_min];
                    wrap_seen++;
                end
            end
            default:
            begin
                for (int i = 0; i < ENTRIES; i++)
                    ring_used[i] = 1'b0;
            end
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        ring_reply_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                ring_used[i]  = 1'b0;
                ring_point[i] = '0;
                ring_owner[i] = '0;
            end
            replies_due.delete();
            fail_count      = 0;
            pending         = 0;
            replies_checked = 0;
            full_seen       = 0;
            nomatch_seen    = 0;
            empty_seen      = 0;
            wrap_seen       = 0;
        end
        else
        begin
            // reply side first so a reply never matches the request taken
            // at the same edge
            if (m_tvalid && m_tready)
            begin
                if (replies_due.size() == 0)
                begin
                    $display("%0t: unexpected reply bucket=%0h status=%0d",
                             $time, m_tdata, m_tuser);
                    fail_count++;
                end
                else
                begin
                    want = replies_due.pop_front();
                    replies_checked++;
                    if (m_tdata !== want.bucket)
                    begin
                        $display("%0t: found_bucket mismatch: expected %0h actual %0h",
                                 $time, want.bucket, m_tdata);
                        fail_count++;
                    end
                    if (m_tuser !== want.status)
                    begin
                        $display("%0t: status mismatch: expected %0d actual %0d",
                                 $time, want.status, m_tuser);
                        fail_count++;
                    end
                    case (want.status)
                        STAT_FULL:    full_seen++;
                        STAT_NOMATCH: nomatch_seen++;
                        STAT_EMPTY:   empty_seen++;
                        default:      ;
                    endcase
                end
            end
            if (s_tvalid && s_tready)
                replies_due = {replies_due,
                               ring_apply(cmd_t'(s_tuser), s_tdata[31:0],
                                          s_tdata[39:32])};
            pending = replies_due.size();
        end
    end

endmodule

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the consistent-hash ring table: a directed opening
// over the corner cases, then random episodes of mixed traffic and of filling
// the ring to capacity, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb;
    import chrt_pkg::*;

    localparam int ENTRIES     = 64;
    localparam int POINT_BITS  = 32;
    localparam int RANDOM_REQS = 400;
    // longest correct quiet spell: sender gap + one scan + receiver stall,
    // well under the limit; the post-reset clearing pass is shorter still
    localparam int QUIET_LIMIT = 4000;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // [31:0] key_point, [39:32] bucket_id
    logic [1:0]  s_tuser;   // [1:0] command
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // [7:0] found_bucket
    logic [1:0]  m_tuser;   // [1:0] status

    int fail_count;
    int pending;
    int replies_checked;
    int full_seen;
    int nomatch_seen;
    int empty_seen;
    int wrap_seen;

    // stimulus bookkeeping: only steers key and owner choice, never checks
    logic [31:0] point_pool [$];
    logic [7:0]  owner_of [logic [31:0]];
    int          sent_by_cmd [4];
    int          rand_sent;
    int          fills_done;
    int          quiet_cycles;
    int          stall_left;
    bit          no_idle;   // set for stretches with back-to-back traffic

    consistent_hash_ring_table_top #(
        .ENTRIES    (ENTRIES),
        .POINT_BITS (POINT_BITS)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    consistent_hash_ring_table_checker #(
        .ENTRIES    (ENTRIES),
        .POINT_BITS (POINT_BITS)
    ) ring_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .fail_count      (fail_count),
        .pending         (pending),
        .replies_checked (replies_checked),
        .full_seen       (full_seen),
        .nomatch_seen    (nomatch_seen),
        .empty_seen      (empty_seen),
        .wrap_seen       (wrap_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // idle length: mostly none or short, now and then a long one
    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 20);
        return $urandom_range(40, 150);
    endfunction

    // keys lean on points already in play (exact hits and neighbors, which
    // exercise the strictly-greater rule) plus the interval ends
    function automatic logic [31:0] pick_key();
        int unsigned r;
        logic [31:0] base;
        r = $urandom_range(0, 99);
        if (point_pool.size() != 0 && r < 52)
        begin
            base = point_pool[$urandom_range(0, point_pool.size() - 1)];
            if (r < 35)
                return base;
            if (r < 45)
                return base + 32'd1;
            return base - 32'd1;
        end
        if (r < 58)
            return 32'h0000_0000;
        if (r < 64)
            return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    // Result channel: random stalls, none during back-to-back stretches.
    initial
    begin
        m_tready   = 1'b0;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if (!no_idle && $urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    // Watchdog: a long spell with no handshake on either channel ends the run.
    initial
    begin
        quiet_cycles = 0;
        do
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        while (quiet_cycles < QUIET_LIMIT);
        $display("%0t: no handshake for %0d cycles, %0d replies outstanding",
                 $time, QUIET_LIMIT, pending);
        $display("CHECKS FAILED");
        $finish;
    end

    // Issues one request. Called at the edge where the previous one was
    // taken, so valid only drops when a gap follows.
    task automatic send_request(cmd_t cmd, logic [31:0] key, logic [7:0] bid);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {bid, key};
        s_tuser  <= cmd;
        do
            @(posedge clk);
        while (!s_tready);
        sent_by_cmd[int'(cmd)]++;
        case (cmd)
            CMD_INSERT:
            begin
                if (!owner_of.exists(key))
                    point_pool = {point_pool, key};
                owner_of[key] = bid;
                if (point_pool.size() > 200)
                    void'(point_pool.pop_front());
            end
            CMD_REMOVE:
                if (owner_of.exists(key) && owner_of[key] == bid)
                    owner_of.delete(key);
            CMD_CLEAR:
            begin
                point_pool.delete();
                owner_of.delete();
            end
            default: ;
        endcase
    endtask

    // Remove mostly with the right owner so points actually leave the ring.
    task automatic send_remove();
        logic [31:0] key;
        logic [7:0]  bid;
        key = pick_key();
        if (owner_of.exists(key) && $urandom_range(0, 9) < 7)
            bid = owner_of[key];
        else
            bid = 8'($urandom_range(0, 255));
        send_request(CMD_REMOVE, key, bid);
    endtask

    // Fill the ring from empty, bounce off the full table, then free one
    // slot and take it again.
    task automatic fill_episode();
        logic [31:0] key;
        send_request(CMD_CLEAR, $urandom, 8'($urandom_range(0, 255)));
        for (int i = 0; i < ENTRIES; i++)
            send_request(CMD_INSERT, $urandom, 8'($urandom_range(0, 255)));
        send_request(CMD_INSERT, $urandom, 8'($urandom_range(0, 255)));
        send_request(CMD_INSERT, 32'hFFFF_FFFF, 8'($urandom_range(0, 255)));
        // overwriting a present point still works on a full table (the pool may also hold a refused point)
        key = point_pool[$urandom_range(0, point_pool.size() - 1)];
        send_request(CMD_INSERT, key, 8'($urandom_range(0, 255)));
        repeat (6) send_request(CMD_LOOKUP, pick_key(), 8'($urandom_range(0, 255)));
        key = point_pool[$urandom_range(0, point_pool.size() - 1)];
        send_request(CMD_REMOVE, key, owner_of[key]);
        send_request(CMD_INSERT, $urandom, 8'($urandom_range(0, 255)));
        send_request(CMD_INSERT, $urandom, 8'($urandom_range(0, 255)));
        send_request(CMD_LOOKUP, pick_key(), 8'($urandom_range(0, 255)));
        fills_done++;
        rand_sent += ENTRIES + 14;
    endtask

    task automatic mixed_episode();
        int n;
        int unsigned r;
        n       = $urandom_range(8, 30);
        no_idle = ($urandom_range(0, 4) == 0);
        repeat (n)
        begin
            r = $urandom_range(0, 99);
            if (r < 35)
                send_request(CMD_INSERT, pick_key(), 8'($urandom_range(0, 255)));
            else if (r < 60)
                send_remove();
            else if (r < 96)
                send_request(CMD_LOOKUP, pick_key(), 8'($urandom_range(0, 255)));
            else
                send_request(CMD_CLEAR, $urandom, 8'($urandom_range(0, 255)));
        end
        no_idle   = 1'b0;
        rand_sent += n;
    endtask

    initial
    begin
        int episode;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = CMD_INSERT;
        no_idle    = 1'b0;
        rand_sent  = 0;
        fills_done = 0;
        for (int i = 0; i < 4; i++)
            sent_by_cmd[i] = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // --- directed opening ---
        // empty ring: lookup reports empty, remove finds nothing, clear is ok
        send_request(CMD_LOOKUP, 32'h1234_5678, 8'h00);
        send_request(CMD_REMOVE, 32'h0000_0000, 8'h00);
        send_request(CMD_CLEAR,  32'hFFFF_FFFF, 8'hFF);
        // points at both ends of the interval and in the middle
        send_request(CMD_INSERT, 32'h0000_0000, 8'h00);
        send_request(CMD_INSERT, 32'hFFFF_FFFF, 8'hFF);
        send_request(CMD_INSERT, 32'h8000_0000, 8'h5A);
        send_request(CMD_LOOKUP, 32'h0000_0000, 8'h00);   // next point up
        send_request(CMD_LOOKUP, 32'h7FFF_FFFF, 8'h00);
        send_request(CMD_LOOKUP, 32'h8000_0000, 8'h00);   // equal point skipped
        send_request(CMD_LOOKUP, 32'hFFFF_FFFF, 8'h00);   // wraps to lowest
        // overwrite an existing point's owner
        send_request(CMD_INSERT, 32'h8000_0000, 8'hA5);
        send_request(CMD_LOOKUP, 32'h0000_0000, 8'h00);
        // remove: wrong owner, absent point, then the real thing
        send_request(CMD_REMOVE, 32'h8000_0000, 8'h5A);
        send_request(CMD_REMOVE, 32'h1234_5678, 8'h00);
        send_request(CMD_REMOVE, 32'h8000_0000, 8'hA5);
        send_request(CMD_LOOKUP, 32'h0000_0000, 8'h00);
        send_request(CMD_REMOVE, 32'h0000_0000, 8'h00);
        // single point left: a lookup at it wraps back onto itself
        send_request(CMD_LOOKUP, 32'hFFFF_FFFF, 8'h00);
        send_request(CMD_INSERT, 32'h5555_5555, 8'hC3);
        send_request(CMD_INSERT, 32'hAAAA_AAAA, 8'h3C);
        send_request(CMD_LOOKUP, 32'h5555_5555, 8'h00);
        send_request(CMD_CLEAR,  32'h0000_0000, 8'h00);
        send_request(CMD_LOOKUP, 32'h0000_0000, 8'h00);

        // --- random episodes; the second one always fills the ring ---
        episode = 0;
        while (rand_sent < RANDOM_REQS)
        begin
            if (episode == 1 || $urandom_range(0, 9) == 0)
                fill_episode();
            else
                mixed_episode();
            episode++;
        end
        s_tvalid <= 1'b0;

        // drain, then give a stray reply time to show up
        do
            @(posedge clk);
        while (pending != 0);
        repeat (ENTRIES + 8) @(posedge clk);

        $display("Ran %0d inserts, %0d removes, %0d lookups, %0d clears; ring filled %0d times.",
                 sent_by_cmd[int'(CMD_INSERT)], sent_by_cmd[int'(CMD_REMOVE)],
                 sent_by_cmd[int'(CMD_LOOKUP)], sent_by_cmd[int'(CMD_CLEAR)],
                 fills_done);
        $display("Checked %0d replies: %0d full, %0d no-match, %0d empty, %0d wrapped lookups.",
                 replies_checked, full_seen, nomatch_seen, empty_seen, wrap_seen);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
